FILE: hw/rtl/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants of the source token lexer
// Token kinds, scan modes and the per-token result record.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int unsigned KindBits = 6;
  localparam int unsigned FieldOfsBits = 24;
  localparam int unsigned FieldLineBits = 20;
  localparam int unsigned MaxTokens = 3;
  localparam int unsigned TokIdxBits = 2;
  localparam int unsigned WordBytes = 5;

  typedef enum logic [3:0] {
    M_IDLE = 4'd0, M_IDENT = 4'd1, M_NUMBER = 4'd2, M_NUMDOT = 4'd3,
    M_FRACTION = 4'd4, M_STRING = 4'd5, M_SLASH = 4'd6, M_COMMENT = 4'd7,
    M_BANG = 4'd8, M_EQUAL = 4'd9, M_LESS = 4'd10, M_GREATER = 4'd11,
    M_AMP = 4'd12, M_PIPE = 4'd13
  } mode_t;

  localparam logic [5:0] K_LPAREN = 6'd0;
  localparam logic [5:0] K_RPAREN = 6'd1;
  localparam logic [5:0] K_LBRACE = 6'd2;
  localparam logic [5:0] K_RBRACE = 6'd3;
  localparam logic [5:0] K_SEMI = 6'd4;
  localparam logic [5:0] K_COMMA = 6'd5;
  localparam logic [5:0] K_MINUS = 6'd6;
  localparam logic [5:0] K_PLUS = 6'd7;
  localparam logic [5:0] K_SLASH = 6'd8;
  localparam logic [5:0] K_STAR = 6'd9;
  localparam logic [5:0] K_PERCENT = 6'd10;
  localparam logic [5:0] K_BANG = 6'd11;
  localparam logic [5:0] K_BANG_EQ = 6'd12;
  localparam logic [5:0] K_EQUAL = 6'd13;
  localparam logic [5:0] K_EQ_EQ = 6'd14;
  localparam logic [5:0] K_ARROW = 6'd15;
  localparam logic [5:0] K_LESS = 6'd16;
  localparam logic [5:0] K_LESS_EQ = 6'd17;
  localparam logic [5:0] K_GREATER = 6'd18;
  localparam logic [5:0] K_GREATER_EQ = 6'd19;
  localparam logic [5:0] K_AND = 6'd20;
  localparam logic [5:0] K_OR = 6'd21;
  localparam logic [5:0] K_IDENT = 6'd22;
  localparam logic [5:0] K_STRING = 6'd23;
  localparam logic [5:0] K_NUMBER = 6'd24;
  localparam logic [5:0] K_LET = 6'd25;
  localparam logic [5:0] K_FALSE = 6'd26;
  localparam logic [5:0] K_FN = 6'd27;
  localparam logic [5:0] K_ELSE = 6'd28;
  localparam logic [5:0] K_IF = 6'd29;
  localparam logic [5:0] K_PRINT = 6'd30;
  localparam logic [5:0] K_TRUE = 6'd31;
  localparam logic [5:0] K_EOF = 6'd32;
  localparam logic [5:0] K_BAD_CHAR = 6'd33;
  localparam logic [5:0] K_OPEN_STRING = 6'd34;

  typedef struct packed {
    logic [KindBits-1:0]      kind;
    logic [FieldOfsBits-1:0]  start;
    logic [FieldOfsBits-1:0]  len;
    logic [FieldLineBits-1:0] line;
  } token_t;

  typedef struct packed {
    logic [TokIdxBits-1:0] count;
    token_t [MaxTokens-1:0] tok;
  } token_group_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Keyword lookup on the first five bytes and the word length.
  function automatic logic [5:0] word_kind(input logic [39:0] w, input logic [2:0] n);
    logic [5:0] k;
    k = K_IDENT;
    if (n == 3'd3 && w[23:0] == 24'h74656c) k = K_LET;
    else if (n == 3'd5 && w == 40'h65736c6166) k = K_FALSE;
    else if (n == 3'd2 && w[15:0] == 16'h6e66) k = K_FN;
    else if (n == 3'd4 && w[31:0] == 32'h65736c65) k = K_ELSE;
    else if (n == 3'd2 && w[15:0] == 16'h6669) k = K_IF;
    else if (n == 3'd5 && w == 40'h746e697270) k = K_PRINT;
    else if (n == 3'd4 && w[31:0] == 32'h65757274) k = K_TRUE;
    return k;
  endfunction

endpackage

FILE: hw/rtl/source_token_lexer.sv
// ----------------------------------------------------------------------------
// source_token_lexer: streaming source text tokenizer
// Scans one byte per request and emits the tokens it completes.
// ----------------------------------------------------------------------------
// Usage: source bytes arrive on the s_axis channel, tdata bit 0..7 the byte,
// tuser the end marker. Each accepted request is scanned in the same cycle and
// its tokens (zero to three) are queued; tokens leave on m_axis one per cycle
// while m_axis_tready is high, tlast on the last token of a request. Tokens
// are registered in the queue before they leave. One byte is taken every
// cycle while the token queue (two requests deep) has room, so throughput is
// one byte per cycle until requests that yield more than one token fill the
// queue faster than the output port drains it. When the receiver stalls, the
// queue fills and s_axis_tready falls; nothing is lost. Reset clears the
// scanner to idle, position zero and line one, and empties the queue. An end
// marker flushes the pending token, emits eof and restarts in the same way.
// ----------------------------------------------------------------------------
module source_token_lexer #(
  parameter int unsigned POSITION_BITS = 24,
  parameter int unsigned LINE_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte
  input  logic        s_axis_tuser,   // [0] end_marker
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] token_kind, [29:6] start_offset, [53:30] token_length,
  // [73:54] line_number, [79:74] zero
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tlast    // last_of_run
);
  import stl_pkg::*;

  token_group_t grp;
  token_t       tok;
  logic         can_load, step;

  assign s_axis_tready = can_load;
  assign step = s_axis_tvalid && can_load;

  stl_scan #(.POSITION_BITS(POSITION_BITS), .LINE_BITS(LINE_BITS)) u_scan (
    .clk, .rst, .step, .source_byte(s_axis_tdata), .end_marker(s_axis_tuser),
    .group(grp)
  );

  stl_out u_out (
    .clk, .rst, .load(step), .group(grp), .can_load,
    .tvalid(m_axis_tvalid), .tready(m_axis_tready), .tok, .tlast(m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, tok.line, tok.len, tok.start, tok.kind};

endmodule

FILE: hw/rtl/stl_scan.sv
// ----------------------------------------------------------------------------
// stl_scan: scanner state and token decision
// Holds the scan state and works out the tokens each accepted request yields.
// ----------------------------------------------------------------------------
module stl_scan #(
  parameter int unsigned POSITION_BITS = 24,
  parameter int unsigned LINE_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           source_byte,
  input  logic                 end_marker,
  output stl_pkg::token_group_t group
);
  import stl_pkg::*;

  localparam logic [POSITION_BITS-1:0] PosMax = '1;
  localparam logic [LINE_BITS-1:0] LineMax = '1;
  localparam logic [POSITION_BITS-1:0] PosOne = POSITION_BITS'(1);
  localparam logic [POSITION_BITS-1:0] PosFive = POSITION_BITS'(5);
  localparam logic [POSITION_BITS:0] LenOne = (POSITION_BITS+1)'(1);
  localparam logic [POSITION_BITS:0] LenTwo = (POSITION_BITS+1)'(2);

  mode_t                   scan_mode, scan_mode_next;
  logic [POSITION_BITS-1:0] byte_position, token_begin, token_begin_next;
  logic [LINE_BITS-1:0]     line_count, line_count_next;
  logic [39:0]              word_prefix, word_prefix_next;

  // Tokens in order; line is filled in at emit time. Lengths carry one extra
  // bit so that a closing quote at the last position still counts fully.
  logic [TokIdxBits-1:0]      n;
  logic [MaxTokens-1:0][5:0]  kd;
  logic [MaxTokens-1:0][POSITION_BITS-1:0] st;
  logic [MaxTokens-1:0][POSITION_BITS:0]   ln;
  logic [LINE_BITS-1:0]       ln_at [MaxTokens];

  function automatic logic [POSITION_BITS-1:0] ssub(input logic [POSITION_BITS-1:0] a,
                                                    input logic [POSITION_BITS-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic logic [FieldOfsBits-1:0] clo(input logic [POSITION_BITS:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'(24'hFFFFFF)) ? '1 : w[FieldOfsBits-1:0];
  endfunction

  function automatic logic [FieldLineBits-1:0] cll(input logic [LINE_BITS-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'(20'hFFFFF)) ? '1 : w[FieldLineBits-1:0];
  endfunction

  always_comb begin
    logic [POSITION_BITS-1:0] cur, dot, wl, idx;
    logic cont, pend, restart;
    logic [7:0] c;
    cur = byte_position;
    c = source_byte;
    n = '0;
    kd = '0;
    st = '0;
    ln = '0;
    for (int i = 0; i < MaxTokens; i++) ln_at[i] = line_count;
    scan_mode_next = scan_mode;
    token_begin_next = token_begin;
    line_count_next = line_count;
    word_prefix_next = word_prefix;
    cont = 1'b0;
    pend = 1'b0;   // pending token must be finished at cur
    restart = 1'b0;
    wl = ssub(cur, token_begin);
    dot = ssub(cur, PosOne);
    idx = ssub(cur, token_begin);
    if (end_marker) begin
      pend = 1'b1;
    end else begin
      unique case (scan_mode)
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            cont = 1'b1;
            // Once the position saturates the same byte slot is hit again.
            if (idx < PosFive)
              word_prefix_next[8*idx[2:0] +: 8] = word_prefix[8*idx[2:0] +: 8] | c;
          end else pend = 1'b1;
        end
        M_NUMBER: begin
          if (is_digit(c)) cont = 1'b1;
          else if (c == 8'h2e) begin cont = 1'b1; scan_mode_next = M_NUMDOT; end
          else pend = 1'b1;
        end
        M_NUMDOT: begin
          if (is_digit(c)) begin cont = 1'b1; scan_mode_next = M_FRACTION; end
          else pend = 1'b1;
        end
        M_FRACTION: begin
          if (is_digit(c)) cont = 1'b1; else pend = 1'b1;
        end
        M_STRING: begin
          cont = 1'b1;
          if (c == 8'h22) begin
            kd[0] = K_STRING; st[0] = token_begin; ln[0] = {1'b0, wl} + LenOne;
            n = 2'd1;
            scan_mode_next = M_IDLE;
          end else if (c == 8'h0a && line_count != LineMax) begin
            line_count_next = line_count + 1'b1;
          end
        end
        M_SLASH: begin
          if (c == 8'h2f) begin cont = 1'b1; scan_mode_next = M_COMMENT; end
          else pend = 1'b1;
        end
        M_COMMENT: begin
          if (c == 8'h0a) scan_mode_next = M_IDLE; else cont = 1'b1;
        end
        M_BANG, M_LESS, M_GREATER, M_EQUAL, M_AMP, M_PIPE: begin
          cont = 1'b1;
          if (c == 8'h3d && scan_mode == M_BANG) kd[0] = K_BANG_EQ;
          else if (c == 8'h3d && scan_mode == M_EQUAL) kd[0] = K_EQ_EQ;
          else if (c == 8'h3e && scan_mode == M_EQUAL) kd[0] = K_ARROW;
          else if (c == 8'h3d && scan_mode == M_LESS) kd[0] = K_LESS_EQ;
          else if (c == 8'h3d && scan_mode == M_GREATER) kd[0] = K_GREATER_EQ;
          else if (c == 8'h26 && scan_mode == M_AMP) kd[0] = K_AND;
          else if (c == 8'h7c && scan_mode == M_PIPE) kd[0] = K_OR;
          else begin cont = 1'b0; pend = 1'b1; end
          if (cont) begin
            st[0] = token_begin; ln[0] = LenTwo; n = 2'd1;
            scan_mode_next = M_IDLE;
          end
        end
        default: scan_mode_next = M_IDLE;
      endcase
    end
    if (pend) begin
      scan_mode_next = M_IDLE;
      unique case (scan_mode)
        M_IDENT: begin
          kd[0] = word_kind(word_prefix, (wl < 7) ? wl[2:0] : 3'd7);
          st[0] = token_begin; ln[0] = {1'b0, wl}; n = 2'd1;
        end
        M_NUMBER, M_FRACTION: begin
          kd[0] = K_NUMBER; st[0] = token_begin; ln[0] = {1'b0, wl}; n = 2'd1;
        end
        M_NUMDOT: begin
          kd[0] = K_NUMBER; st[0] = token_begin; ln[0] = {1'b0, ssub(dot, token_begin)};
          kd[1] = K_BAD_CHAR; st[1] = dot; ln[1] = LenOne; n = 2'd2;
        end
        M_STRING: begin
          kd[0] = K_OPEN_STRING; st[0] = token_begin; ln[0] = {1'b0, wl}; n = 2'd1;
        end
        M_SLASH:   begin kd[0] = K_SLASH;   st[0] = token_begin; ln[0] = LenOne; n = 2'd1; end
        M_BANG:    begin kd[0] = K_BANG;    st[0] = token_begin; ln[0] = LenOne; n = 2'd1; end
        M_EQUAL:   begin kd[0] = K_EQUAL;   st[0] = token_begin; ln[0] = LenOne; n = 2'd1; end
        M_LESS:    begin kd[0] = K_LESS;    st[0] = token_begin; ln[0] = LenOne; n = 2'd1; end
        M_GREATER: begin kd[0] = K_GREATER; st[0] = token_begin; ln[0] = LenOne; n = 2'd1; end
        M_AMP, M_PIPE: begin
          kd[0] = K_BAD_CHAR; st[0] = token_begin; ln[0] = LenOne; n = 2'd1;
        end
        default: ;
      endcase
    end
    if (end_marker) begin
      kd[n] = K_EOF; st[n] = cur; ln[n] = '0; n = n + 1'b1;
      restart = 1'b1;
    end else if (!cont && (scan_mode_next == M_IDLE)) begin
      // Start a fresh token with this byte.
      token_begin_next = cur;
      if (c == 8'h20 || c == 8'h0d || c == 8'h09) begin
      end else if (c == 8'h0a) begin
        if (line_count != LineMax) line_count_next = line_count + 1'b1;
      end else if (is_alpha(c)) begin
        scan_mode_next = M_IDENT; word_prefix_next = {32'd0, c};
      end else if (is_digit(c)) begin
        scan_mode_next = M_NUMBER;
      end else begin
        unique case (c)
          8'h22: scan_mode_next = M_STRING;
          8'h2f: scan_mode_next = M_SLASH;
          8'h21: scan_mode_next = M_BANG;
          8'h3d: scan_mode_next = M_EQUAL;
          8'h3c: scan_mode_next = M_LESS;
          8'h3e: scan_mode_next = M_GREATER;
          8'h26: scan_mode_next = M_AMP;
          8'h7c: scan_mode_next = M_PIPE;
          default: begin
            unique case (c)
              8'h28: kd[n] = K_LPAREN;
              8'h29: kd[n] = K_RPAREN;
              8'h7b: kd[n] = K_LBRACE;
              8'h7d: kd[n] = K_RBRACE;
              8'h3b: kd[n] = K_SEMI;
              8'h2c: kd[n] = K_COMMA;
              8'h2d: kd[n] = K_MINUS;
              8'h2b: kd[n] = K_PLUS;
              8'h2a: kd[n] = K_STAR;
              8'h25: kd[n] = K_PERCENT;
              default: kd[n] = K_BAD_CHAR;
            endcase
            st[n] = cur; ln[n] = LenOne; n = n + 1'b1;
          end
        endcase
      end
    end
    // A newline itself never emits a token; any token emitted with it ends before it,
    // so line at emit is the count before this byte.
    group.count = n;
    for (int i = 0; i < MaxTokens; i++) begin
      group.tok[i].kind = kd[i];
      group.tok[i].start = clo({1'b0, st[i]});
      group.tok[i].len = clo(ln[i]);
      group.tok[i].line = cll(ln_at[i]);
    end
    if (restart) begin
      scan_mode_next = M_IDLE;
      token_begin_next = '0;
      line_count_next = LINE_BITS'(1);
      word_prefix_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= M_IDLE;
      byte_position <= '0;
      token_begin <= '0;
      line_count <= LINE_BITS'(1);
      word_prefix <= '0;
    end else if (step) begin
      scan_mode <= scan_mode_next;
      token_begin <= token_begin_next;
      line_count <= line_count_next;
      word_prefix <= word_prefix_next;
      if (end_marker) byte_position <= '0;
      else if (byte_position != PosMax) byte_position <= byte_position + 1'b1;
    end
  end

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst) line_count != '0)
    else $error("line count reached zero");
  a_eof_resets: assert property (@(posedge clk) disable iff (rst)
    step && end_marker |=> byte_position == '0 && scan_mode == M_IDLE)
    else $error("end marker did not restart the scanner");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    step |-> group.count != 2'd0 || !end_marker)
    else $error("end marker produced no eof token");

endmodule

FILE: hw/rtl/stl_out.sv
// ----------------------------------------------------------------------------
// stl_out: result buffer and serialiser
// Holds up to two token groups and sends their tokens one per ready cycle.
// ----------------------------------------------------------------------------
module stl_out (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  stl_pkg::token_group_t group,
  output logic                  can_load,
  output logic                  tvalid,
  input  logic                  tready,
  output stl_pkg::token_t       tok,
  output logic                  tlast
);
  import stl_pkg::*;

  // Two-entry queue of groups; the head is drained token by token.
  token_group_t          q [2];
  logic [1:0]            fill;
  logic                  wr_ptr, rd_ptr;
  logic [TokIdxBits-1:0] sel;
  logic                  pop, done;

  assign tvalid = fill != 2'd0;
  assign tok = q[rd_ptr].tok[sel];
  assign tlast = (sel == q[rd_ptr].count - 1'b1);
  assign done = tvalid && tready && tlast;
  // Accept when a slot is free or the head finishes this cycle.
  assign can_load = (fill != 2'd2) || done;
  assign pop = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      sel <= '0;
    end else begin
      if (tvalid && tready) sel <= tlast ? '0 : sel + 1'b1;
      if (pop) rd_ptr <= ~rd_ptr;
      if (load && group.count != '0) wr_ptr <= ~wr_ptr;
      fill <= fill + 2'((load && group.count != '0) ? 1 : 0) - 2'(pop ? 1 : 0);
    end
  end

  always_ff @(posedge clk) begin
    if (load && group.count != '0) q[wr_ptr] <= group;
  end

  a_fill_max: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("queue overflow");
  a_sel_range: assert property (@(posedge clk) disable iff (rst)
    tvalid |-> sel < q[rd_ptr].count)
    else $error("token select past group");
  a_pop_fill: assert property (@(posedge clk) disable iff (rst)
    pop && !load |=> fill == $past(fill) - 2'd1)
    else $error("pop lost");

endmodule
